// ===== hdl/cls_pkg.sv =====
// ----------------------------------------------------------------------------
// cls_pkg: shared definitions for the compacting list store
// Widths, operation codes and result status codes that are used by the
// channel interfaces and by the core.
// ----------------------------------------------------------------------------
package cls_pkg;

	// Number of list entries.
	localparam int DEPTH = 8;

	// Width of the fill count, which must hold DEPTH itself.
	localparam int CNT_W = $clog2(DEPTH + 1);
	// Width of an entry index.
	localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	// Payload field widths.
	localparam int OP_W   = 2;
	localparam int DATA_W = 32;
	localparam int STAT_W = 3;
	localparam int POS_W  = 6;

	// Operation codes.
	localparam logic [OP_W-1:0] OP_INSERT  = 2'd0;
	localparam logic [OP_W-1:0] OP_DELETE  = 2'd1;
	localparam logic [OP_W-1:0] OP_FORWARD = 2'd2;
	localparam logic [OP_W-1:0] OP_REVERSE = 2'd3;

	// Result status codes.
	localparam logic [STAT_W-1:0] STAT_STORED   = 3'd0;
	localparam logic [STAT_W-1:0] STAT_FULL     = 3'd1;
	localparam logic [STAT_W-1:0] STAT_EMPTY    = 3'd2;
	localparam logic [STAT_W-1:0] STAT_NOTFOUND = 3'd3;
	localparam logic [STAT_W-1:0] STAT_DELETED  = 3'd4;
	localparam logic [STAT_W-1:0] STAT_ELEMENT  = 3'd5;

endpackage

// ===== hdl/cls_req_if.sv =====
// ----------------------------------------------------------------------------
// cls_req_if: request channel of the compacting list store
// Carries one operation and its data word per transfer.
// ----------------------------------------------------------------------------
interface cls_req_if;

	logic                              valid;
	logic                              ready;
	logic [cls_pkg::OP_W-1:0]          op;
	logic signed [cls_pkg::DATA_W-1:0] data_value;

	modport source (output valid, output op, output data_value, input ready);
	modport sink   (input valid, input op, input data_value, output ready);

endinterface

// ===== hdl/cls_rsp_if.sv =====
// ----------------------------------------------------------------------------
// cls_rsp_if: response channel of the compacting list store
// Carries one result per transfer, with a flag on the final one of a request.
// ----------------------------------------------------------------------------
interface cls_rsp_if;

	logic                              valid;
	logic                              ready;
	logic [cls_pkg::STAT_W-1:0]        status;
	logic signed [cls_pkg::DATA_W-1:0] item_value;
	logic [cls_pkg::POS_W-1:0]         position;
	logic                              last;

	modport source (output valid, output status, output item_value, output position,
		output last, input ready);
	modport sink   (input valid, input status, input item_value, input position,
		input last, output ready);

endinterface

// ===== hdl/cls_ram.sv =====
// ----------------------------------------------------------------------------
// cls_ram: generic simple dual-port RAM
// One write port and one read port; read data is registered and holds its
// value while no read is issued.
// ----------------------------------------------------------------------------
module cls_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 8
) (
	input  logic                                     clk,
	input  logic                                     we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                         wdata,
	input  logic                                     re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== hdl/compacting_list_store_core.sv =====
// ----------------------------------------------------------------------------
// compacting_list_store_core: bounded list of signed words in a RAM
// Appends, deletes by value with compaction, and reads the list out in
// either order. The entries live in a registered-read RAM; a sequencer
// issues reads and writes and drives one output register.
//
//   Channel  Dir  Transfer content
//   -------  ---  ----------------------------------------------------------
//   req      in   op, data_value: one operation
//   rsp      out  status, item_value, position, last: one result
//
// Insert, and any delete or read-out on an empty list, goes straight to the
// report state. Delete compares entries up to and including the first match,
// then moves each later entry down by one; a delete that finds nothing
// reports once all entries are compared. A read-out delivers one element
// per cycle while rsp does not stall, bounded by the single RAM read port.
// A new request is taken once the previous one has handed its final result
// to the output register. Reset clears the count; the RAM needs no clearing.
// A stalled rsp holds the sequencer in place during read-out and report.
// ----------------------------------------------------------------------------
module compacting_list_store_core (
	input  logic clk,
	input  logic arst_n,
	cls_req_if.sink   req,
	cls_rsp_if.source rsp
);

	import cls_pkg::*;

	// Sequencer states.
	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_SCAN   = 3'd1;
	localparam logic [2:0] S_SHIFT  = 3'd2;
	localparam logic [2:0] S_READ   = 3'd3;
	localparam logic [2:0] S_REPORT = 3'd4;

	logic [2:0]               state_q;
	logic [CNT_W-1:0]         count_q;
	logic [CNT_W-1:0]         ptr_q;
	logic                     rev_q;
	logic [DATA_W-1:0]        val_q;
	logic [IDX_W-1:0]         pos_q;
	logic [STAT_W-1:0]        rep_q;

	logic                     vld_s1;
	logic [IDX_W-1:0]         idx_s1;
	logic                     last_s1;

	logic                     rsp_valid_q;
	logic [STAT_W-1:0]        status_q;
	logic [DATA_W-1:0]        item_q;
	logic [POS_W-1:0]         position_q;
	logic                     last_q;

	logic                     accept;
	logic                     out_free;
	logic                     is_full;
	logic                     issue_more;
	logic                     match;
	logic [CNT_W-1:0]         count_m1;
	logic [CNT_W-1:0]         ro_addr;

	logic                     ram_we;
	logic [IDX_W-1:0]         ram_waddr;
	logic [DATA_W-1:0]        ram_wdata;
	logic                     ram_re;
	logic [IDX_W-1:0]         ram_raddr;
	logic [DATA_W-1:0]        ram_rdata;

	logic                     emit;
	logic [STAT_W-1:0]        emit_status;
	logic [DATA_W-1:0]        emit_value;
	logic [POS_W-1:0]         emit_pos;
	logic                     emit_last;

	// Handshake and common conditions.
	assign req.ready  = (state_q == S_IDLE);
	assign accept     = req.valid && req.ready;
	assign out_free   = !rsp_valid_q || rsp.ready;
	assign is_full    = (count_q == CNT_W'(DEPTH));
	assign issue_more = (ptr_q < count_q);
	assign count_m1   = count_q - CNT_W'(1);
	assign ro_addr    = rev_q ? (count_m1 - ptr_q) : ptr_q;
	assign match      = vld_s1 && (ram_rdata == val_q);

	// Entry storage.
	cls_ram #(
		.WIDTH (DATA_W),
		.DEPTH (DEPTH)
	) u_entries (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// RAM port control. During compaction the read address runs two entries
	// above the write address, so the two ports never meet on the same entry.
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = count_q[IDX_W-1:0];
		ram_wdata = req.data_value;
		ram_re    = 1'b0;
		ram_raddr = ptr_q[IDX_W-1:0];
		case (state_q)
			S_IDLE: begin
				ram_we = accept && (req.op == OP_INSERT) && !is_full;
			end
			S_SCAN: begin
				ram_re = issue_more;
			end
			S_SHIFT: begin
				ram_re    = issue_more;
				ram_we    = vld_s1;
				ram_waddr = idx_s1 - IDX_W'(1);
				ram_wdata = ram_rdata;
			end
			S_READ: begin
				ram_re    = issue_more && (!vld_s1 || out_free);
				ram_raddr = ro_addr[IDX_W-1:0];
			end
			default: begin
				ram_re = 1'b0;
			end
		endcase
	end

	// Result selection for the output register.
	always_comb begin
		emit        = 1'b0;
		emit_status = rep_q;
		emit_value  = '0;
		emit_pos    = '0;
		emit_last   = 1'b1;
		case (state_q)
			S_READ: begin
				emit        = vld_s1 && out_free;
				emit_status = STAT_ELEMENT;
				emit_value  = ram_rdata;
				emit_pos    = POS_W'(idx_s1);
				emit_last   = last_s1;
			end
			S_REPORT: begin
				emit = out_free;
				if (rep_q == STAT_DELETED) begin
					emit_value = val_q;
					emit_pos   = POS_W'(pos_q);
				end
			end
			default: begin
				emit = 1'b0;
			end
		endcase
	end

	// Sequencer: count, issue pointer and read pipeline stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			ptr_q   <= '0;
			rev_q   <= 1'b0;
			vld_s1  <= 1'b0;
			rep_q   <= STAT_STORED;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						rev_q  <= (req.op == OP_REVERSE);
						ptr_q  <= '0;
						vld_s1 <= 1'b0;
						case (req.op)
							OP_INSERT: begin
								if (is_full) begin
									rep_q <= STAT_FULL;
								end else begin
									rep_q   <= STAT_STORED;
									count_q <= count_q + CNT_W'(1);
								end
								state_q <= S_REPORT;
							end
							OP_DELETE: begin
								if (count_q == '0) begin
									rep_q   <= STAT_EMPTY;
									state_q <= S_REPORT;
								end else begin
									state_q <= S_SCAN;
								end
							end
							default: begin
								if (count_q == '0) begin
									rep_q   <= STAT_EMPTY;
									state_q <= S_REPORT;
								end else begin
									state_q <= S_READ;
								end
							end
						endcase
					end
				end
				S_SCAN: begin
					if (match) begin
						// First match: move the later entries down from here.
						ptr_q   <= CNT_W'(idx_s1) + CNT_W'(1);
						vld_s1  <= 1'b0;
						state_q <= S_SHIFT;
					end else if (vld_s1 && (idx_s1 == count_m1[IDX_W-1:0])) begin
						rep_q   <= STAT_NOTFOUND;
						vld_s1  <= 1'b0;
						state_q <= S_REPORT;
					end else begin
						vld_s1 <= issue_more;
						if (issue_more) begin
							ptr_q <= ptr_q + CNT_W'(1);
						end
					end
				end
				S_SHIFT: begin
					vld_s1 <= issue_more;
					if (issue_more) begin
						ptr_q <= ptr_q + CNT_W'(1);
					end else if (!vld_s1) begin
						count_q <= count_m1;
						rep_q   <= STAT_DELETED;
						state_q <= S_REPORT;
					end
				end
				S_READ: begin
					if (ram_re) begin
						vld_s1 <= 1'b1;
						ptr_q  <= ptr_q + CNT_W'(1);
					end else if (emit) begin
						vld_s1 <= 1'b0;
					end
					if (emit && last_s1) begin
						state_q <= S_IDLE;
					end
				end
				S_REPORT: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Request payload and read stage tags.
	always_ff @(posedge clk) begin
		if (accept) begin
			val_q <= req.data_value;
		end
		if (state_q == S_SCAN && match) begin
			pos_q <= idx_s1;
		end
		if (ram_re) begin
			idx_s1  <= (state_q == S_READ) ? ro_addr[IDX_W-1:0] : ptr_q[IDX_W-1:0];
			last_s1 <= (ptr_q == count_m1);
		end
	end

	// Output register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (emit) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (emit) begin
			status_q   <= emit_status;
			item_q     <= emit_value;
			position_q <= emit_pos;
			last_q     <= emit_last;
		end
	end

	assign rsp.valid      = rsp_valid_q;
	assign rsp.status     = status_q;
	assign rsp.item_value = item_q;
	assign rsp.position   = position_q;
	assign rsp.last       = last_q;

	// The fill count never passes the list depth.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("list count exceeds depth");

	// Read and write ports never address the same entry in one cycle.
	a_port_apart: assert property (@(posedge clk) disable iff (!arst_n)
		(ram_we && ram_re) |-> (ram_waddr != ram_raddr))
		else $error("RAM read and write collide");

	// An insert into a list with room grows the count by one.
	a_insert_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (req.op == OP_INSERT) && !is_full) |=>
		(count_q == $past(count_q) + CNT_W'(1)))
		else $error("insert did not grow the count");

	// No read stays in flight once the sequencer is back at rest.
	a_idle_drained: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> !vld_s1)
		else $error("read stage busy while idle");

endmodule

// ===== sim/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: self-checking testbench for compacting_list_store_core
// Drives insert, delete and read-out requests through the request channel and
// keeps its own model of the list contents and fill count. Every response
// transfer is compared field by field with the oldest predicted result. The
// sender works in bursts with random gaps, and the receiver stalls in phases.
// ----------------------------------------------------------------------------
module tb_top;

	timeunit 1ns;
	timeprecision 1ps;

	import cls_pkg::*;

	// One predicted or observed response transfer.
	typedef struct packed {
		logic [STAT_W-1:0]        status;
		logic signed [DATA_W-1:0] item_value;
		logic [POS_W-1:0]         position;
		logic                     last;
	} list_result_t;

	logic clk = 1'b0;
	logic arst_n;

	cls_req_if req_ch ();
	cls_rsp_if rsp_ch ();

	compacting_list_store_core dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	// Shadow copy of the list, updated as each request transfer is accepted.
	logic signed [DATA_W-1:0] list_words [DEPTH];
	int                       list_count = 0;
	list_result_t             expected_results [$];

	int fail_count = 0;
	int burst_left = 0;
	int stall_mode = 0;
	int stall_left = 0;
	list_result_t got_result;
	list_result_t want_result;

	// 12 ns clock.
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Generous overall limit on the run.
	initial begin
		#(2_000_000);
		$display("tb_top: FAIL");
		$finish;
	end

	function automatic void push_result(input logic [STAT_W-1:0] status,
			input logic signed [DATA_W-1:0] item_value, input int position, input logic last);
		list_result_t r;
		r.status     = status;
		r.item_value = item_value;
		r.position   = POS_W'(position);
		r.last       = last;
		expected_results.push_back(r);
	endfunction

	// Apply one accepted request to the shadow list and queue its results.
	function automatic void predict_list_op(input logic [OP_W-1:0] op,
			input logic signed [DATA_W-1:0] value);
		int hit;
		int k;
		int idx;
		hit = -1;
		case (op)
		OP_INSERT: begin
			if (list_count >= DEPTH) begin
				push_result(STAT_FULL, '0, 0, 1'b1);
			end else begin
				list_words[list_count] = value;
				list_count++;
				push_result(STAT_STORED, '0, 0, 1'b1);
			end
		end
		OP_DELETE: begin
			if (list_count == 0) begin
				push_result(STAT_EMPTY, '0, 0, 1'b1);
			end else begin
				for (k = 0; k < list_count; k++)
					if (hit < 0 && list_words[k] == value)
						hit = k;
				if (hit < 0) begin
					push_result(STAT_NOTFOUND, '0, 0, 1'b1);
				end else begin
					// Close the gap; the top slot is simply abandoned.
					for (k = hit; k < list_count - 1; k++)
						list_words[k] = list_words[k + 1];
					list_count--;
					push_result(STAT_DELETED, value, hit, 1'b1);
				end
			end
		end
		default: begin
			if (list_count == 0) begin
				push_result(STAT_EMPTY, '0, 0, 1'b1);
			end else begin
				for (k = 0; k < list_count; k++) begin
					idx = (op == OP_FORWARD) ? k : list_count - 1 - k;
					push_result(STAT_ELEMENT, list_words[idx], idx, k == list_count - 1);
				end
			end
		end
		endcase
	endfunction

	// Random data word, biased toward extremes and a few nearby small values
	// so that duplicates and matches come up often.
	function automatic logic signed [DATA_W-1:0] pick_word();
		int offset;
		offset = $urandom_range(0, 6);
		case ($urandom_range(0, 9))
		0: begin
			return 32'sh8000_0000;
		end
		1: begin
			return 32'sh7fff_ffff;
		end
		2, 3, 4, 5: begin
			return offset - 3;
		end
		default: begin
			return $urandom;
		end
		endcase
	endfunction

	// Delete key: mostly a value that is present, otherwise any word.
	function automatic logic signed [DATA_W-1:0] pick_delete_word();
		if (list_count > 0 && $urandom_range(0, 3) != 0)
			return list_words[$urandom_range(0, list_count - 1)];
		return pick_word();
	endfunction

	// Send one request. Back-to-back transfers within a burst keep valid high;
	// the burst ends with valid lowered and a gap before the next one.
	task automatic send_request(input logic [OP_W-1:0] op,
			input logic signed [DATA_W-1:0] value);
		if (burst_left == 0) begin
			repeat ($urandom_range(1, 6)) @(posedge clk);
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
				: $urandom_range(1, 8);
		end
		req_ch.valid      <= 1'b1;
		req_ch.op         <= op;
		req_ch.data_value <= value;
		do
			@(posedge clk);
		while (req_ch.ready !== 1'b1);
		predict_list_op(op, value);
		burst_left--;
		if (burst_left == 0)
			req_ch.valid <= 1'b0;
	endtask

	// Delete and both read-outs on an empty list.
	task automatic test_empty_list();
		send_request(OP_DELETE, 32'sd7);
		send_request(OP_FORWARD, 32'sd0);
		send_request(OP_REVERSE, -32'sd1);
	endtask

	// Fill with extreme and alternating-bit words plus a duplicate, overflow
	// once, then read the full list out in both directions.
	task automatic test_fill_to_full();
		send_request(OP_INSERT, 32'sh8000_0000);
		send_request(OP_INSERT, 32'sh7fff_ffff);
		send_request(OP_INSERT, 32'sd0);
		send_request(OP_INSERT, -32'sd1);
		send_request(OP_INSERT, 32'sd5);
		send_request(OP_INSERT, 32'sd5);
		send_request(OP_INSERT, 32'sh5555_5555);
		send_request(OP_INSERT, 32'shaaaa_aaaa);
		send_request(OP_INSERT, 32'sd1);
		send_request(OP_FORWARD, 32'sh5555_5555);
		send_request(OP_REVERSE, 32'shaaaa_aaaa);
	endtask

	// Missing key, first of two duplicates, head, tail and a middle entry.
	task automatic test_delete_cases();
		send_request(OP_DELETE, 32'sd123);
		send_request(OP_DELETE, 32'sd5);
		send_request(OP_DELETE, 32'sh8000_0000);
		send_request(OP_DELETE, 32'shaaaa_aaaa);
		send_request(OP_DELETE, 32'sd0);
		send_request(OP_FORWARD, 32'sd0);
	endtask

	// Full cycles from empty to full and back, deleting in random order.
	task automatic test_fill_drain_cycles(input int rounds);
		repeat (rounds) begin
			while (list_count < DEPTH)
				send_request(OP_INSERT, pick_word());
			send_request(OP_INSERT, pick_word());
			send_request(OP_FORWARD, pick_word());
			while (list_count > 0) begin
				send_request(OP_DELETE, list_words[$urandom_range(0, list_count - 1)]);
				if ($urandom_range(0, 3) == 0)
					send_request(OP_REVERSE, pick_word());
			end
			send_request(OP_DELETE, pick_word());
			send_request($urandom_range(0, 1) ? OP_FORWARD : OP_REVERSE, pick_word());
		end
	endtask

	// Weighted random mix of all operations.
	task automatic test_random_mix(input int n_items);
		int pick;
		repeat (n_items) begin
			pick = $urandom_range(0, 99);
			if (pick < 40)
				send_request(OP_INSERT, pick_word());
			else if (pick < 70)
				send_request(OP_DELETE, pick_delete_word());
			else if (pick < 85)
				send_request(OP_FORWARD, pick_word());
			else
				send_request(OP_REVERSE, pick_word());
		end
	endtask

	// Receiver: drives ready in stall phases and checks every response transfer.
	always @(posedge clk) begin
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
		end else begin
			if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
				got_result.status     = rsp_ch.status;
				got_result.item_value = rsp_ch.item_value;
				got_result.position   = rsp_ch.position;
				got_result.last       = rsp_ch.last;
				if (expected_results.size() == 0) begin
					$display("%0t: unexpected result status=%0d value=%0d pos=%0d last=%0b",
						$time, got_result.status, got_result.item_value,
						got_result.position, got_result.last);
					fail_count++;
				end else begin
					want_result = expected_results.pop_front();
					if (got_result.status !== want_result.status
							|| got_result.item_value !== want_result.item_value
							|| got_result.position !== want_result.position
							|| got_result.last !== want_result.last) begin
						$display("%0t: mismatch expected status=%0d value=%0d pos=%0d last=%0b",
							$time, want_result.status, want_result.item_value,
							want_result.position, want_result.last);
						$display("%0t:          actual   status=%0d value=%0d pos=%0d last=%0b",
							$time, got_result.status, got_result.item_value,
							got_result.position, got_result.last);
						fail_count++;
					end
				end
			end
			// Stall phases: always ready, random, or mostly stalled.
			if (stall_left == 0) begin
				stall_mode = $urandom_range(0, 2);
				stall_left = $urandom_range(8, 40);
			end else begin
				stall_left--;
			end
			case (stall_mode)
			0: begin
				rsp_ch.ready <= 1'b1;
			end
			1: begin
				rsp_ch.ready <= $urandom_range(0, 1);
			end
			default: begin
				rsp_ch.ready <= ($urandom_range(0, 3) == 0);
			end
			endcase
		end
	end

	// Test sequence.
	initial begin
		arst_n            <= 1'b0;
		req_ch.valid      <= 1'b0;
		req_ch.op         <= OP_INSERT;
		req_ch.data_value <= '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		test_empty_list();
		test_fill_to_full();
		test_delete_cases();
		test_fill_drain_cycles(6);
		test_random_mix(280);

		// Stop sending and let the remaining results come out.
		if (burst_left != 0) begin
			req_ch.valid <= 1'b0;
			burst_left = 0;
		end
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);

		if (fail_count == 0)
			$display("tb_top: PASS");
		else
			$display("tb_top: FAIL");
		$finish;
	end

endmodule

// ===== sim.f =====
hdl/cls_pkg.sv
hdl/cls_req_if.sv
hdl/cls_rsp_if.sv
hdl/cls_ram.sv
hdl/compacting_list_store_core.sv
sim/tb_top.sv
